>>> rtl/recency_weighted_max_heap_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recency weighted max heap core
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RECENCY_WEIGHTED_MAX_HEAP_CORE_MACROS_SVH
`define RECENCY_WEIGHTED_MAX_HEAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RWMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rwmh assertion failed");
`define RWMH_ASSERT_IMPL(lbl, ante, cons) \
  `RWMH_ASSERT(lbl, (ante) |-> (cons))
`else
`define RWMH_ASSERT(lbl, prop)
`define RWMH_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> rtl/rwmh_pkg.sv
// ----------------------------------------------------------------------------
// rwmh_pkg
// Types, codes and the score function of the recency weighted max heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rwmh_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 32;

  localparam logic [2:0] FUNC_INSERT   = 3'd0;
  localparam logic [2:0] FUNC_TOUCH    = 3'd1;
  localparam logic [2:0] FUNC_EXTRACT  = 3'd2;
  localparam logic [2:0] FUNC_PEEK     = 3'd3;
  localparam logic [2:0] FUNC_CONTAINS = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [19:0] frequency;
    logic [31:0] timestamp;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] out_key;
    logic [19:0] out_frequency;
    logic [31:0] out_timestamp;
    logic [26:0] out_score;
    logic        evicted;
    logic [31:0] evicted_key;
  } res_t;

  typedef struct packed {
    logic [31:0] key;
    logic [19:0] cnt;
    logic [31:0] ts;
    logic [26:0] score;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // The age is a signed difference, so a timestamp in the future is recent.
  function automatic logic [26:0] score_of(logic [19:0] freq, logic [31:0] ts,
                                           logic [31:0] now);
    logic signed [32:0] age;
    logic [7:0]         bonus;
    logic [26:0]        base;
    age = $signed({1'b0, now}) - $signed({1'b0, ts});
    if (age < 33'sd300) bonus = 8'd200;
    else if (age < 33'sd1800) bonus = 8'd100;
    else if (age < 33'sd3600) bonus = 8'd50;
    else if (age < 33'sd86400) bonus = 8'd25;
    else bonus = 8'd0;
    base = 27'(freq) * 27'd100;
    return base + 27'(bonus);
  endfunction

endpackage

>>> rtl/recency_weighted_max_heap_core.sv
// ----------------------------------------------------------------------------
// recency_weighted_max_heap_core
// Binary max heap of keyed entries scored by use count and recency.
// ----------------------------------------------------------------------------
// Contains scans the keys; peek reads the top entry and extract also sifts
//   the last entry down from the root; insert and touch take the key scan, a
//   minimum scan over all entries when full, plus sift steps per heap
//   level, all through the single entry RAM.
// One item at a time: busy is high from accept until the result strobe.
// Reset clears the state and the occupancy; the entry RAM is not cleared.
`timescale 1ns / 1ps
`include "recency_weighted_max_heap_core_macros.svh"
module recency_weighted_max_heap_core #(
  parameter int unsigned CAPACITY = rwmh_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rwmh_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output rwmh_pkg::res_t res_o
);
  import rwmh_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] CAP = IW'(CAPACITY);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FIND_RD = 5'd1;
  localparam logic [4:0] S_FIND_CK = 5'd2;
  localparam logic [4:0] S_DECIDE  = 5'd3;
  localparam logic [4:0] S_MIN_RD  = 5'd4;
  localparam logic [4:0] S_MIN_CK  = 5'd5;
  localparam logic [4:0] S_EVICT   = 5'd6;
  localparam logic [4:0] S_EVI_LD  = 5'd7;
  localparam logic [4:0] S_NEW     = 5'd8;
  localparam logic [4:0] S_UP      = 5'd9;
  localparam logic [4:0] S_UP_CK   = 5'd10;
  localparam logic [4:0] S_DN      = 5'd11;
  localparam logic [4:0] S_DN_L    = 5'd12;
  localparam logic [4:0] S_DN_R    = 5'd13;
  localparam logic [4:0] S_TOP_RD  = 5'd14;
  localparam logic [4:0] S_TOP_CK  = 5'd15;
  localparam logic [4:0] S_EXT_LD  = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  localparam logic [1:0] M_REWRITE = 2'd0;
  localparam logic [1:0] M_EVICT   = 2'd1;
  localparam logic [1:0] M_ADD     = 2'd2;
  localparam logic [1:0] M_EXTRACT = 2'd3;

  logic [4:0]    state_q, state_d;
  logic [IW-1:0] occ_q, occ_d;
  logic [IW-1:0] scan_q, scan_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [IW-1:0] mi_q, mi_d;
  logic [1:0]    mode_q, mode_d;
  logic          moved_q, moved_d;
  logic          lbig_q, lbig_d;
  logic [26:0]   min_q, min_d;
  cmd_t          cmd_q, cmd_d;
  res_t          res_q, res_d;
  entry_t        hent_q, hent_d;
  entry_t        ent_q, ent_d;
  entry_t        new_q, new_d;
  entry_t        lent_q, lent_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic [IW-1:0] occ_m1, parent;
  logic [IW:0]   lidx, ridx, occ_x;
  logic [19:0]   nfreq;
  logic [31:0]   nts;
  logic [26:0]   bigscore;

  rwmh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign occ_m1 = occ_q - 1'b1;
  assign parent = (idx_q - 1'b1) >> 1;
  assign lidx   = {idx_q, 1'b1};
  assign ridx   = lidx + 1'b1;
  assign occ_x  = {1'b0, occ_q};
  assign bigscore = lbig_q ? lent_q.score : ent_q.score;

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    scan_d  = scan_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    mi_d    = mi_q;
    mode_d  = mode_q;
    moved_d = moved_q;
    lbig_d  = lbig_q;
    min_d   = min_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    hent_d  = hent_q;
    ent_d   = ent_q;
    new_d   = new_q;
    lent_d  = lent_q;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = ent_q;
    raddr   = '0;
    nfreq   = cmd_q.frequency;
    nts     = cmd_q.timestamp;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d  = cmd_i;
          res_d  = '0;
          scan_d = '0;
          if (cmd_i.func == FUNC_INSERT || cmd_i.func == FUNC_TOUCH ||
              cmd_i.func == FUNC_CONTAINS) begin
            state_d = S_FIND_RD;
          end else if (cmd_i.func == FUNC_EXTRACT || cmd_i.func == FUNC_PEEK) begin
            state_d = S_TOP_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FIND_RD: begin
        raddr = scan_q[AW-1:0];
        if (scan_q == occ_q) state_d = S_DECIDE;
        else state_d = S_FIND_CK;
      end
      S_FIND_CK: begin
        if (rdata.key == cmd_q.key) begin
          res_d.found = 1'b1;
          hit_d   = scan_q;
          hent_d  = rdata;
          state_d = S_DECIDE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_DECIDE: begin
        if (cmd_q.func == FUNC_TOUCH) begin
          nts = cmd_q.now;
          if (!res_q.found) nfreq = 20'd1;
          else if (hent_q.cnt == '1) nfreq = hent_q.cnt;
          else nfreq = hent_q.cnt + 1'b1;
        end
        new_d.key   = cmd_q.key;
        new_d.cnt   = nfreq;
        new_d.ts    = nts;
        new_d.score = score_of(nfreq, nts, cmd_q.now);
        if (cmd_q.func == FUNC_CONTAINS) begin
          state_d = S_DONE;
        end else begin
          res_d.out_key       = cmd_q.key;
          res_d.out_frequency = nfreq;
          res_d.out_timestamp = nts;
          res_d.out_score     = new_d.score;
          if (res_q.found) begin
            ent_d   = new_d;
            idx_d   = hit_q;
            mode_d  = M_REWRITE;
            moved_d = 1'b0;
            state_d = S_UP;
          end else if (occ_q == CAP) begin
            scan_d  = '0;
            state_d = S_MIN_RD;
          end else begin
            state_d = S_NEW;
          end
        end
      end
      S_MIN_RD: begin
        raddr = scan_q[AW-1:0];
        if (scan_q == occ_q) state_d = S_EVICT;
        else state_d = S_MIN_CK;
      end
      S_MIN_CK: begin
        // The first entry with the lowest score wins.
        if (scan_q == '0 || rdata.score < min_q) begin
          min_d = rdata.score;
          mi_d  = scan_q;
          res_d.evicted_key = rdata.key;
        end
        scan_d  = scan_q + 1'b1;
        state_d = S_MIN_RD;
      end
      S_EVICT: begin
        res_d.evicted = 1'b1;
        occ_d   = occ_m1;
        raddr   = occ_m1[AW-1:0];
        state_d = S_EVI_LD;
      end
      S_EVI_LD: begin
        ent_d   = rdata;
        idx_d   = mi_q;
        mode_d  = M_EVICT;
        moved_d = 1'b0;
        state_d = S_UP;
      end
      S_NEW: begin
        ent_d   = new_q;
        idx_d   = occ_q;
        occ_d   = occ_q + 1'b1;
        mode_d  = M_ADD;
        state_d = S_UP;
      end
      S_UP: begin
        raddr = parent[AW-1:0];
        if (idx_q != '0) begin
          state_d = S_UP_CK;
        end else if (mode_q == M_ADD || moved_q) begin
          we      = 1'b1;
          state_d = (mode_q == M_EVICT) ? S_NEW : S_DONE;
        end else begin
          state_d = S_DN;
        end
      end
      S_UP_CK: begin
        // The held entry rises through a hole; parents move down behind it.
        if (ent_q.score > rdata.score) begin
          we      = 1'b1;
          wdata   = rdata;
          idx_d   = parent;
          moved_d = 1'b1;
          state_d = S_UP;
        end else if (mode_q == M_ADD || moved_q) begin
          we      = 1'b1;
          state_d = (mode_q == M_EVICT) ? S_NEW : S_DONE;
        end else begin
          state_d = S_DN;
        end
      end
      S_DN: begin
        raddr = lidx[AW-1:0];
        if (lidx < occ_x) begin
          state_d = S_DN_L;
        end else begin
          we      = 1'b1;
          state_d = (mode_q == M_EVICT) ? S_NEW : S_DONE;
        end
      end
      S_DN_L: begin
        lent_d = rdata;
        lbig_d = rdata.score > ent_q.score;
        raddr  = ridx[AW-1:0];
        if (ridx < occ_x) begin
          state_d = S_DN_R;
        end else if (rdata.score > ent_q.score) begin
          we      = 1'b1;
          wdata   = rdata;
          idx_d   = lidx[IW-1:0];
          state_d = S_DN;
        end else begin
          we      = 1'b1;
          state_d = (mode_q == M_EVICT) ? S_NEW : S_DONE;
        end
      end
      S_DN_R: begin
        if (rdata.score > bigscore) begin
          we      = 1'b1;
          wdata   = rdata;
          idx_d   = ridx[IW-1:0];
          state_d = S_DN;
        end else if (lbig_q) begin
          we      = 1'b1;
          wdata   = lent_q;
          idx_d   = lidx[IW-1:0];
          state_d = S_DN;
        end else begin
          we      = 1'b1;
          state_d = (mode_q == M_EVICT) ? S_NEW : S_DONE;
        end
      end
      S_TOP_RD: begin
        raddr = '0;
        if (occ_q == '0) state_d = S_DONE;
        else state_d = S_TOP_CK;
      end
      S_TOP_CK: begin
        res_d.found         = 1'b1;
        res_d.out_key       = rdata.key;
        res_d.out_frequency = rdata.cnt;
        res_d.out_timestamp = rdata.ts;
        res_d.out_score     = rdata.score;
        raddr = occ_m1[AW-1:0];
        if (cmd_q.func == FUNC_PEEK) begin
          state_d = S_DONE;
        end else begin
          occ_d = occ_m1;
          if (occ_m1 == '0) state_d = S_DONE;
          else state_d = S_EXT_LD;
        end
      end
      S_EXT_LD: begin
        ent_d   = rdata;
        idx_d   = '0;
        mode_d  = M_EXTRACT;
        state_d = S_DN;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    mi_q    <= mi_d;
    mode_q  <= mode_d;
    moved_q <= moved_d;
    lbig_q  <= lbig_d;
    min_q   <= min_d;
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    hent_q  <= hent_d;
    ent_q   <= ent_d;
    new_q   <= new_d;
    lent_q  <= lent_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  `RWMH_ASSERT(a_occ_bound, occ_q <= CAP)
  `RWMH_ASSERT_IMPL(a_strobe_single, res_valid_o, ##1 !res_valid_o)
  `RWMH_ASSERT_IMPL(a_occ_step, !$stable(occ_q),
                    occ_q == IW'($past(occ_q) + 1'b1) || occ_q == IW'($past(occ_q) - 1'b1))
  `RWMH_ASSERT_IMPL(a_no_write_idle, state_q == S_IDLE, !we)
endmodule

>>> rtl/rwmh_ram.sv
// ----------------------------------------------------------------------------
// rwmh_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rwmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
